/* sv/sfpq_pkg.sv */
// shared types, constants and codes for the split fifo / priority task queues
package sfpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int POS_W       = 5;
  localparam int TID_W       = 16;
  localparam int BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] THRESHOLD_RESET = 8'd7;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [TID_W-1:0]  tid_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // opcodes
  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_DUMP_FIFO = 2'd1;
  localparam logic [1:0] OP_DUMP_PRIO = 2'd2;

  // result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_DUMPED   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // queue select codes
  localparam logic Q_FIFO = 1'b0;
  localparam logic Q_PRIO = 1'b1;

  typedef struct packed {
    id_t   id;
    byte_t run;
    byte_t prio;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted item
    logic insert;     // perform insert and load its result
    logic dump_load;  // load one dump result and step the index
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       dump_last;
    logic       out_free;
  } stat_t;

endpackage

/* sv/split_fifo_priority_queues_unit.sv */
// top level of the split fifo / priority task queues
//
// Two task queues of 16 entries each. An insert (opcode 0) sends the task
// to the fifo queue when its run time is at or above long_task_threshold
// (reset 7), otherwise into the priority queue, which is kept sorted with
// the highest priority at the head; a new task goes ahead of stored tasks of
// equal priority. Each insert gives one result: inserted with its slot, or
// dropped (position 0) when the queue is full. A dump (opcode 1 fifo,
// opcode 2 priority) streams every entry from the head without removing
// any, with last set on the final one; an empty queue gives one empty result.
// Opcode 3 is taken and ignored. An insert goes through capture, then a
// compare and shift across the row of priority cells into the output
// register; a dump streams one entry per cycle through the read mux of the
// selected row while the result side does not stall. A stall on the result
// side holds the sequencer; the next item is taken as soon as the previous
// one has loaded its last result into the output register.
module split_fifo_priority_queues_unit (
  input  logic                clk,
  input  logic                rst,
  // configuration: long task threshold
  input  logic                cfg_write_en,
  input  sfpq_pkg::byte_t     cfg_write_data,
  // task input channel
  input  logic                task_valid,
  output logic                task_ready,
  input  logic [1:0]          opcode,
  input  sfpq_pkg::tid_t      task_id,
  input  sfpq_pkg::byte_t     run_time,
  input  sfpq_pkg::byte_t     task_priority,
  // result output channel
  output logic                result_valid,
  input  logic                result_ready,
  output logic                queue_select,
  output logic [1:0]          status,
  output sfpq_pkg::pos_t      position,
  output sfpq_pkg::tid_t      out_task_id,
  output sfpq_pkg::byte_t     out_run_time,
  output sfpq_pkg::byte_t     out_priority,
  output logic                last
);

  // command and status between sequencer and datapath
  sfpq_pkg::cmd_t  cmd;
  sfpq_pkg::stat_t st;

  // sequencer: one transfer in, then insert or stream the dump
  sfpq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .task_valid (task_valid),
    .task_ready (task_ready),
    .st         (st),
    .cmd        (cmd)
  );

  // storage, insert logic and the output register
  sfpq_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .opcode         (opcode),
    .task_id        (task_id),
    .run_time       (run_time),
    .task_priority  (task_priority),
    .cmd            (cmd),
    .st             (st),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .queue_select   (queue_select),
    .status         (status),
    .position       (position),
    .out_task_id    (out_task_id),
    .out_run_time   (out_run_time),
    .out_priority   (out_priority),
    .last           (last)
  );

endmodule

/* sv/sfpq_ctrl.sv */
// controller state machine: sequences capture, insert and dump streaming
module sfpq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             task_valid,
  output logic             task_ready,
  input  sfpq_pkg::stat_t  st,
  output sfpq_pkg::cmd_t   cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    task_ready    = 1'b0;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        task_ready = 1'b1;
        if (task_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (st.op) inside
          sfpq_pkg::OP_INSERT: begin
            if (st.out_free) begin
              cmd.insert = 1'b1;
              state_next = S_IDLE;
            end
          end
          sfpq_pkg::OP_DUMP_FIFO, sfpq_pkg::OP_DUMP_PRIO: begin
            if (st.out_free) begin
              cmd.dump_load = 1'b1;
              if (st.dump_last) begin
                state_next = S_IDLE;
              end
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/sfpq_dp.sv */
// datapath: item register, fifo row, sorted cell row, dump read and output register
module sfpq_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  sfpq_pkg::byte_t      cfg_write_data,
  input  logic [1:0]           opcode,
  input  sfpq_pkg::tid_t       task_id,
  input  sfpq_pkg::byte_t      run_time,
  input  sfpq_pkg::byte_t      task_priority,
  input  sfpq_pkg::cmd_t       cmd,
  output sfpq_pkg::stat_t      st,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic                 queue_select,
  output logic [1:0]           status,
  output sfpq_pkg::pos_t       position,
  output sfpq_pkg::tid_t       out_task_id,
  output sfpq_pkg::byte_t      out_run_time,
  output sfpq_pkg::byte_t      out_priority,
  output logic                 last
);

  localparam int DEPTH = sfpq_pkg::QUEUE_DEPTH;

  // current item
  logic [1:0]        cur_op;
  sfpq_pkg::entry_t  cur;
  sfpq_pkg::idx_t    dump_idx;
  sfpq_pkg::byte_t   threshold;

  // queue storage
  sfpq_pkg::entry_t  fifo_row [DEPTH];
  sfpq_pkg::cnt_t    fifo_fill;
  sfpq_pkg::entry_t  ord_row  [DEPTH];
  sfpq_pkg::cnt_t    ord_fill;

  // insert decisions
  logic              to_fifo;
  logic              fifo_full;
  logic              ord_full;
  logic [DEPTH-1:0]  ahead;      // stored cell stays ahead of the new task
  logic [DEPTH-1:0]  put_here;   // one-hot slot of the new task
  sfpq_pkg::idx_t    ord_pos;

  // dump read
  logic              dump_prio;
  sfpq_pkg::cnt_t    dump_fill;
  logic              dump_empty;
  sfpq_pkg::entry_t  dump_entry;
  sfpq_pkg::cnt_t    idx_plus;

  assign to_fifo   = (cur.run >= threshold);
  assign fifo_full = (fifo_fill == sfpq_pkg::cnt_t'(DEPTH));
  assign ord_full  = (ord_fill == sfpq_pkg::cnt_t'(DEPTH));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ahead[i] = (sfpq_pkg::cnt_t'(i) < ord_fill) && (ord_row[i].prio > cur.prio);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        put_here[i] = !ahead[i];
      end else begin
        put_here[i] = !ahead[i] && ahead[i-1];
      end
    end
    ord_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (put_here[i]) begin
        ord_pos = ord_pos | sfpq_pkg::idx_t'(i);
      end
    end
  end

  assign dump_prio  = (cur_op == sfpq_pkg::OP_DUMP_PRIO);
  assign dump_fill  = dump_prio ? ord_fill : fifo_fill;
  assign dump_empty = (dump_fill == '0);
  assign dump_entry = dump_prio ? ord_row[dump_idx] : fifo_row[dump_idx];
  assign idx_plus   = sfpq_pkg::cnt_t'({1'b0, dump_idx} + 1'b1);

  assign st.op        = cur_op;
  assign st.dump_last = dump_empty || (idx_plus == dump_fill);
  assign st.out_free  = !result_valid || result_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= sfpq_pkg::THRESHOLD_RESET;
      fifo_fill    <= '0;
      ord_fill     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        threshold <= cfg_write_data;
      end
      if (cmd.insert) begin
        if (to_fifo) begin
          if (!fifo_full) begin
            fifo_fill <= sfpq_pkg::cnt_t'(fifo_fill + 1'b1);
          end
        end else if (!ord_full) begin
          ord_fill <= sfpq_pkg::cnt_t'(ord_fill + 1'b1);
        end
      end
      if (cmd.insert || cmd.dump_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // item register and dump index
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_op   <= opcode;
      cur.id   <= task_id[sfpq_pkg::ID_WIDTH-1:0];
      cur.run  <= run_time;
      cur.prio <= task_priority;
      dump_idx <= '0;
    end else if (cmd.dump_load) begin
      dump_idx <= sfpq_pkg::idx_t'(dump_idx + 1'b1);
    end
  end

  // fifo row: append at fill
  always_ff @(posedge clk) begin
    if (cmd.insert && to_fifo && !fifo_full) begin
      fifo_row[fifo_fill[sfpq_pkg::IDX_W-1:0]] <= cur;
    end
  end

  // sorted cell row: cells behind the slot shift back one place
  always_ff @(posedge clk) begin
    if (cmd.insert && !to_fifo && !ord_full) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (put_here[i]) begin
          ord_row[i] <= cur;
        end else if (i > 0 && !ahead[i-1]) begin
          ord_row[i] <= ord_row[i-1];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      queue_select <= to_fifo ? sfpq_pkg::Q_FIFO : sfpq_pkg::Q_PRIO;
      out_task_id  <= sfpq_pkg::tid_t'(cur.id);
      out_run_time <= cur.run;
      out_priority <= cur.prio;
      last         <= 1'b1;
      if (to_fifo ? fifo_full : ord_full) begin
        status   <= sfpq_pkg::ST_DROPPED;
        position <= '0;
      end else begin
        status   <= sfpq_pkg::ST_INSERTED;
        position <= to_fifo ? sfpq_pkg::pos_t'(fifo_fill) : sfpq_pkg::pos_t'(ord_pos);
      end
    end else if (cmd.dump_load) begin
      queue_select <= dump_prio ? sfpq_pkg::Q_PRIO : sfpq_pkg::Q_FIFO;
      last         <= st.dump_last;
      if (dump_empty) begin
        status       <= sfpq_pkg::ST_EMPTY;
        position     <= '0;
        out_task_id  <= '0;
        out_run_time <= '0;
        out_priority <= '0;
      end else begin
        status       <= sfpq_pkg::ST_DUMPED;
        position     <= sfpq_pkg::pos_t'(dump_idx);
        out_task_id  <= sfpq_pkg::tid_t'(dump_entry.id);
        out_run_time <= dump_entry.run;
        out_priority <= dump_entry.prio;
      end
    end
  end

endmodule

/* sim/testbench.sv */
// self-checking testbench for split_fifo_priority_queues_unit, with a built-in two-queue model
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sfpq_pkg::*;

  // opcode 3 is taken by the block and ignored
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // cycles with no transfer on either channel before the run is abandoned
  localparam int STALL_LIMIT      = 2000;
  // quiet cycles after the last result, before a threshold write and at the end
  localparam int SETTLE_CYCLES    = 8;
  // insert and dump items per random phase, ignored items not counted
  localparam int ITEMS_PER_PHASE  = 40;
  localparam int MAX_PRINTED_ERRS = 20;

  typedef struct packed {
    logic [1:0] op;
    tid_t       id;
    byte_t      run;
    byte_t      prio;
  } task_req_t;

  typedef struct packed {
    logic       qsel;
    logic [1:0] st;
    pos_t       pos;
    tid_t       id;
    byte_t      run;
    byte_t      prio;
    logic       last;
  } task_result_t;

  // clock, reset and block inputs, all known from time zero
  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       cfg_write_en   = 1'b0;
  byte_t      cfg_write_data = '0;
  logic       task_valid     = 1'b0;
  logic [1:0] opcode         = OP_IGNORED;
  tid_t       task_id        = '0;
  byte_t      run_time       = '0;
  byte_t      task_priority  = '0;
  logic       result_ready   = 1'b0;

  // block outputs
  logic       task_ready;
  logic       result_valid;
  logic       queue_select;
  logic [1:0] status;
  pos_t       position;
  tid_t       out_task_id;
  byte_t      out_run_time;
  byte_t      out_priority;
  logic       last;

  // model of the two queues and of the threshold register
  entry_t     fifo_rows [QUEUE_DEPTH];
  int         fifo_count      = 0;
  entry_t     prio_rows [QUEUE_DEPTH];
  int         prio_count      = 0;
  byte_t      threshold_model = THRESHOLD_RESET;

  task_req_t     pending_tasks [$];
  task_result_t  expected_results [$];

  // idle chances in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  logic task_fire = 1'b0;
  int   quiet_cycles  = 0;
  int   error_count   = 0;
  int   task_count    = 0;
  int   result_count  = 0;
  int   drop_count    = 0;
  int   dump_entries  = 0;
  int   setting_count = 0;

  always #4 clk = ~clk;

  split_fifo_priority_queues_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .task_valid     (task_valid),
    .task_ready     (task_ready),
    .opcode         (opcode),
    .task_id        (task_id),
    .run_time       (run_time),
    .task_priority  (task_priority),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .queue_select   (queue_select),
    .status         (status),
    .position       (position),
    .out_task_id    (out_task_id),
    .out_run_time   (out_run_time),
    .out_priority   (out_priority),
    .last           (last)
  );

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED_ERRS) begin
      $display("%0t ns: mismatch, %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  task automatic add_result(input logic qsel, input logic [1:0] st, input int slot,
                            input entry_t e, input logic is_last);
    task_result_t r;
    r.qsel = qsel;
    r.st   = st;
    r.pos  = pos_t'(slot);
    r.id   = tid_t'(e.id);
    r.run  = e.run;
    r.prio = e.prio;
    r.last = is_last;
    expected_results.push_back(r);
  endtask

  // a dump walks one queue from the head and leaves it untouched
  task automatic expect_dump(input logic qsel);
    int     count;
    entry_t e;
    count = (qsel == Q_FIFO) ? fifo_count : prio_count;
    if (count == 0) begin
      add_result(qsel, ST_EMPTY, 0, '0, 1'b1);
    end
    for (int k = 0; k < count; k++) begin
      e = (qsel == Q_FIFO) ? fifo_rows[k] : prio_rows[k];
      add_result(qsel, ST_DUMPED, k, e, k == count - 1);
      dump_entries++;
    end
  endtask

  // expected results of one accepted transfer on the task channel
  task automatic predict_queue_results(input task_req_t req);
    entry_t e;
    int     slot;
    e.id   = req.id[ID_WIDTH-1:0];
    e.run  = req.run;
    e.prio = req.prio;
    case (req.op)
      OP_DUMP_FIFO: begin
        task_count++;
        expect_dump(Q_FIFO);
      end
      OP_DUMP_PRIO: begin
        task_count++;
        expect_dump(Q_PRIO);
      end
      OP_INSERT: begin
        task_count++;
        if (req.run >= threshold_model) begin
          // long task: append to the fifo queue unless it is full
          if (fifo_count >= QUEUE_DEPTH) begin
            add_result(Q_FIFO, ST_DROPPED, 0, e, 1'b1);
            drop_count++;
          end else begin
            fifo_rows[fifo_count] = e;
            add_result(Q_FIFO, ST_INSERTED, fifo_count, e, 1'b1);
            fifo_count++;
          end
        end else if (prio_count >= QUEUE_DEPTH) begin
          add_result(Q_PRIO, ST_DROPPED, 0, e, 1'b1);
          drop_count++;
        end else begin
          // first slot whose priority is not above the new one: ties go behind the new task
          slot = 0;
          while (slot < prio_count && prio_rows[slot].prio > e.prio) begin
            slot++;
          end
          for (int k = prio_count; k > slot; k--) begin
            prio_rows[k] = prio_rows[k-1];
          end
          prio_rows[slot] = e;
          prio_count++;
          add_result(Q_PRIO, ST_INSERTED, slot, e, 1'b1);
        end
      end
      default: begin
        // ignored opcode: no result, no state change
      end
    endcase
  endtask

  // driver: a new item only after the previous one was transferred
  always @(negedge clk) begin
    task_req_t req;
    if (!rst && (!task_valid || task_fire)) begin
      if (pending_tasks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_tasks.pop_front();
        opcode        <= req.op;
        task_id       <= req.id;
        run_time      <= req.run;
        task_priority <= req.prio;
        task_valid    <= 1'b1;
      end else begin
        task_valid <= 1'b0;
      end
    end
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: check each result transfer, then predict from each task transfer
  always @(posedge clk) begin
    task_result_t want;
    task_fire <= task_valid && task_ready;
    if (!rst && result_valid && result_ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("queue_select", queue_select, want.qsel);
        check_field("status", status, want.st);
        check_field("position", position, want.pos);
        check_field("out_task_id", out_task_id, want.id);
        check_field("out_run_time", out_run_time, want.run);
        check_field("out_priority", out_priority, want.prio);
        check_field("last", last, want.last);
      end
    end
    if (!rst && task_valid && task_ready) begin
      predict_queue_results(task_req_t'({opcode, task_id, run_time, task_priority}));
    end
  end

  // watchdog: too long without any transfer means the block hung
  always @(posedge clk) begin
    if ((task_valid && task_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_task(input logic [1:0] op, input tid_t id, input byte_t run,
                            input byte_t prio);
    pending_tasks.push_back(task_req_t'({op, id, run, prio}));
  endtask

  // random item; returns 1 when it is an insert or a dump, 0 for ignored noise
  task automatic queue_random_task(output bit counted);
    int unsigned pick;
    byte_t       run;
    byte_t       prio;
    logic [1:0]  op;
    byte_t       tie_prios [5];
    tie_prios = '{8'd0, 8'd1, 8'd127, 8'd254, 8'd255};
    pick = $urandom_range(99);
    if (pick < 8) begin
      op = OP_DUMP_FIFO;
    end else if (pick < 16) begin
      op = OP_DUMP_PRIO;
    end else if (pick < 21) begin
      op = OP_IGNORED;
    end else begin
      op = OP_INSERT;
    end
    // a quarter of run times sit right at the threshold boundary
    run = byte_t'($urandom);
    if ($urandom_range(3) == 0) begin
      run = threshold_model + byte_t'($urandom_range(2)) - 8'd1;
    end
    // half the priorities come from a small set so that ties are frequent
    prio = byte_t'($urandom);
    if ($urandom_range(1) == 0) begin
      prio = tie_prios[$urandom_range(4)];
    end
    queue_task(op, tid_t'($urandom), run, prio);
    counted = (op != OP_IGNORED);
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_tasks.size() != 0 || task_valid || expected_results.size() != 0);
    // an ignored item gives no result, so allow the block to finish with it
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic write_threshold(input byte_t value);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en    <= 1'b0;
    threshold_model = value;
    setting_count++;
  endtask

  initial begin
    byte_t       phase_thresholds [5];
    int unsigned phase_send_idle [5];
    int unsigned phase_recv_idle [5];
    int          done;
    bit          counted;

    phase_thresholds = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd128};
    phase_send_idle  = '{13, 13, 56, 56, 0};
    phase_recv_idle  = '{56, 56, 13, 13, 0};
    phase_thresholds[2] = byte_t'($urandom_range(2, 254));

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 56;

    // directed part at the reset threshold of 7
    queue_task(OP_DUMP_FIFO, 16'h0000, 8'd0, 8'd0);      // empty fifo queue
    queue_task(OP_DUMP_PRIO, 16'h0000, 8'd0, 8'd0);      // empty priority queue
    queue_task(OP_IGNORED, 16'hffff, 8'hff, 8'hff);      // ignored opcode
    queue_task(OP_INSERT, 16'h0000, 8'd0, 8'd0);         // lowest fields, priority queue
    queue_task(OP_INSERT, 16'hffff, 8'd6, 8'd255);       // just below threshold, new head
    queue_task(OP_INSERT, 16'h1234, 8'd7, 8'd0);         // exactly at threshold, fifo
    queue_task(OP_INSERT, 16'hffff, 8'd255, 8'd255);     // highest fields, fifo
    queue_task(OP_INSERT, 16'h0005, 8'd0, 8'd0);         // tie at the tail
    queue_task(OP_INSERT, 16'h0006, 8'd3, 8'd255);       // tie with the head
    queue_task(OP_INSERT, 16'h0007, 8'd1, 8'd128);       // lands in the middle
    queue_task(OP_DUMP_PRIO, 16'h5555, 8'haa, 8'h55);
    queue_task(OP_DUMP_FIFO, 16'haaaa, 8'h55, 8'haa);
    queue_task(OP_IGNORED, 16'h0000, 8'd0, 8'd0);
    wait_drained();

    // random phases, each under its own threshold and idle pattern
    for (int p = 0; p < 5; p++) begin
      write_threshold(phase_thresholds[p]);
      send_idle_pct = phase_send_idle[p];
      recv_idle_pct = phase_recv_idle[p];
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        queue_random_task(counted);
        if (counted) begin
          done++;
        end
      end
      // a dump of each queue closes the phase so the full contents are seen
      queue_task(OP_DUMP_FIFO, tid_t'($urandom), 8'd0, 8'd0);
      queue_task(OP_DUMP_PRIO, tid_t'($urandom), 8'd0, 8'd0);
      wait_drained();
    end

    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end

    $display("covered %0d inserts and dumps, %0d results checked, %0d dumped entries,",
             task_count, result_count, dump_entries);
    $display("%0d dropped tasks, %0d threshold settings, %0d mismatches",
             drop_count, setting_count, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
